// ===== hw/rtl/phgc_pkg.sv =====
package phgc_pkg;

    localparam int unsigned MUL_W  = 24;
    localparam int unsigned DIV_W  = 24;
    localparam int unsigned DEN_W  = 8;
    localparam int unsigned HUE_W  = 16;
    localparam int unsigned LVL_W  = 17;
    localparam int unsigned STEP_W = 8;
    localparam int unsigned MANT_W = 24;
    localparam int unsigned FRAC_W = 23;

    localparam logic [LVL_W-1:0]  Q_ONE     = 17'h10000;
    localparam logic [STEP_W-1:0] MAX_GLIDE = 8'd255;

    localparam logic [1:0] REG_GLIDE = 2'd0;
    localparam logic [1:0] REG_SAT   = 2'd1;
    localparam logic [1:0] REG_VAL   = 2'd2;

    localparam logic [STEP_W-1:0] GLIDE_RST = 8'd36;
    localparam logic [LVL_W-1:0]  SAT_RST   = 17'd65536;
    localparam logic [LVL_W-1:0]  VAL_RST   = 17'd64881;

    typedef struct packed {
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DEN_W-1:0] divisor;
    } t_div_req;

endpackage

// ===== hw/rtl/phgc_mul.sv =====
module phgc_mul
    import phgc_pkg::*;
(
    input  logic               i_clk,
    input  t_mul_req           i_req,
    output logic [2*MUL_W-1:0] o_prod
);

    logic [2*MUL_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_req.a * i_req.b;
    end

    assign o_prod = r_prod;

endmodule

// ===== hw/rtl/phgc_div.sv =====
module phgc_div
    import phgc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_req         i_req,
    output logic             o_busy,
    output logic [DIV_W-1:0] o_quot
);

    localparam int unsigned CNT_W = $clog2(DIV_W + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [DIV_W-1:0] r_quo;
    logic [DEN_W:0]   w_trial;
    logic             w_fits;

    assign w_trial = {r_rem, r_quo[DIV_W-1]};
    assign w_fits  = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DIV_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_den <= i_req.divisor;
            r_quo <= i_req.dividend;
        end else if (r_busy) begin
            r_rem <= w_fits ? DEN_W'(w_trial - {1'b0, r_den}) : DEN_W'(w_trial);
            r_quo <= {r_quo[DIV_W-2:0], w_fits};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quo;

endmodule

// ===== hw/rtl/pitch_to_hue_glide_color_core.sv =====
// pitch to hue glide color core
// input stream: one pitch sample per request in s_axis_tdata (unsigned 16.8 Hz)
// output stream: one color per request in m_axis_tdata, red, green, blue, hue
// config: apb registers glide_steps (0x0), saturation_level (0x4), value_level (0x8)
// the hue of a new target is frac(log2(pitch)) from a piecewise linear table,
// the shown hue glides from the old target toward it over glide_steps requests;
// pitch samples arriving mid glide only advance the glide
// the color comes from hsv to rgb using one shared 24x24 multiplier for all products
// a new target waits on normalization, which shifts out the leading zeros of the pitch
// one at a time; a zero pitch skips normalization and the table lookup, and a glide
// step waits on the bit-serial 24 bit divider
// one request is in work at a time; s_axis_tready is high only while idle, so the
// next request is taken no sooner than the cycle after the result is loaded
// the result waits in an output register; a stalled receiver holds the finished
// color there and the next request may be taken meanwhile
// reset restores the register defaults and clears the glide state (no target yet)
module pitch_to_hue_glide_color_core
    import phgc_pkg::*;
#(
    parameter int LOG_TABLE_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // pitch_hz
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // red_level, green_level, blue_level, hue_shown
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned KW = $clog2(LOG_TABLE_DEPTH + 1);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_NORM   = 4'd1;
    localparam logic [3:0] ST_KMUL   = 4'd2;
    localparam logic [3:0] ST_LUT    = 4'd3;
    localparam logic [3:0] ST_INTERP = 4'd4;
    localparam logic [3:0] ST_GMUL   = 4'd5;
    localparam logic [3:0] ST_DSTART = 4'd6;
    localparam logic [3:0] ST_DWAIT  = 4'd7;
    localparam logic [3:0] ST_HP     = 4'd8;
    localparam logic [3:0] ST_HSF    = 4'd9;
    localparam logic [3:0] ST_HQ     = 4'd10;
    localparam logic [3:0] ST_HSFN   = 4'd11;
    localparam logic [3:0] ST_HT     = 4'd12;
    localparam logic [3:0] ST_OUT    = 4'd13;
    localparam logic [3:0] ST_TT     = 4'd14;

    function automatic logic [LVL_W-1:0] log_entry(input int k);
        logic [63:0] x;
        logic [19:0] r;
        x = (64'd1 << 30) + ((64'(k) << 30) / LOG_TABLE_DEPTH);
        r = '0;
        for (int i = 0; i < 18; i++) begin
            x = (x * x) >> 30;
            r = r << 1;
            if (x >= (64'd2 << 30)) begin
                r = r | 20'd1;
                x = x >> 1;
            end
        end
        return LVL_W'((r + 20'd2) >> 2);
    endfunction

    function automatic logic [HUE_W-1:0] sat16(input logic [LVL_W-1:0] v);
        return v[HUE_W] ? {HUE_W{1'b1}} : v[HUE_W-1:0];
    endfunction

    logic [LVL_W-1:0] w_tab [LOG_TABLE_DEPTH+1];

    for (genvar gk = 0; gk < LOG_TABLE_DEPTH; gk++) begin : g_tab
        assign w_tab[gk] = log_entry(gk);
    end
    assign w_tab[LOG_TABLE_DEPTH] = Q_ONE;

    // configuration registers
    logic [STEP_W-1:0] r_glide_steps;
    logic [LVL_W-1:0]  r_sat;
    logic [LVL_W-1:0]  r_val;
    logic              w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_glide_steps <= GLIDE_RST;
            r_sat         <= SAT_RST;
            r_val         <= VAL_RST;
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                REG_GLIDE: r_glide_steps <= pwdata[STEP_W-1:0];
                REG_SAT:   r_sat         <= pwdata[LVL_W-1:0];
                REG_VAL:   r_val         <= pwdata[LVL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_GLIDE: prdata = 32'(r_glide_steps);
            REG_SAT:   prdata = 32'(r_sat);
            REG_VAL:   prdata = 32'(r_val);
            default:   prdata = '0;
        endcase
    end

    // sequencer state
    logic [3:0]        r_state;
    logic [MANT_W-1:0] r_mant;
    logic              r_zero;
    logic [KW-1:0]     r_kidx;
    logic [FRAC_W-1:0] r_rfrac;
    logic [LVL_W-1:0]  r_lo;
    logic [HUE_W-1:0]  r_shown;
    logic [LVL_W-1:0]  r_pp;
    logic [LVL_W-1:0]  r_qq;
    logic [LVL_W-1:0]  r_tt;
    logic [HUE_W-1:0]  r_start;
    logic [HUE_W-1:0]  r_target;
    logic [LVL_W-1:0]  r_dist;
    logic [STEP_W-1:0] r_pos;
    logic              r_out_valid;
    logic [63:0]       r_out_data;

    t_mul_req           w_mul_req;
    logic [2*MUL_W-1:0] w_prod;
    t_div_req           w_div_req;
    logic               w_div_busy;
    logic [DIV_W-1:0]   w_quot;

    phgc_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (w_mul_req),
        .o_prod (w_prod)
    );

    phgc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_busy  (w_div_busy),
        .o_quot  (w_quot)
    );

    logic [STEP_W-1:0] w_steps;
    logic [LVL_W-1:0]  w_s;
    logic [LVL_W-1:0]  w_v;
    logic              w_mid;
    logic [KW-1:0]     w_kidx1;
    logic [LVL_W-1:0]  w_lo;
    logic [LVL_W-1:0]  w_hi;
    logic [LVL_W-1:0]  w_diff;
    logic [LVL_W:0]    w_interp;
    logic [HUE_W-1:0]  w_newhue;
    logic signed [17:0] w_draw;
    logic signed [17:0] w_fold;
    logic [LVL_W-1:0]  w_mag;
    logic [HUE_W-1:0]  w_off;
    logic [18:0]       w_h6;
    logic [2:0]        w_sector;
    logic [HUE_W-1:0]  w_f;
    logic [LVL_W-1:0]  w_prodq;
    logic [LVL_W-1:0]  w_rr;
    logic [LVL_W-1:0]  w_gg;
    logic [LVL_W-1:0]  w_bb;
    logic              w_accept;
    logic              w_out_load;

    always_comb begin
        if (r_glide_steps == '0) begin
            w_steps = STEP_W'(1);
        end else if (r_glide_steps > MAX_GLIDE) begin
            w_steps = MAX_GLIDE;
        end else begin
            w_steps = r_glide_steps;
        end
    end

    assign w_s   = (r_sat > Q_ONE) ? Q_ONE : r_sat;
    assign w_v   = (r_val > Q_ONE) ? Q_ONE : r_val;
    assign w_mid = (r_pos != '0) && (r_pos < w_steps);

    assign w_kidx1  = r_kidx + KW'(1);
    assign w_lo     = w_tab[r_kidx];
    assign w_hi     = w_tab[w_kidx1];
    assign w_diff   = (w_hi > w_lo) ? (w_hi - w_lo) : '0;
    assign w_interp = {1'b0, r_lo} + {1'b0, w_prod[FRAC_W +: LVL_W]};
    assign w_newhue = r_zero ? '0 :
                      ((w_interp > (LVL_W+1)'(16'hFFFF)) ? 16'hFFFF : w_interp[HUE_W-1:0]);

    // shorter signed wrap distance, a half circle tie steps against the raw difference
    assign w_draw = $signed({2'b00, w_newhue}) - $signed({2'b00, r_target});
    always_comb begin
        if (w_draw >= 18'sd32768) begin
            w_fold = w_draw - 18'sd65536;
        end else if (w_draw <= -18'sd32768) begin
            w_fold = w_draw + 18'sd65536;
        end else begin
            w_fold = w_draw;
        end
    end

    assign w_mag    = r_dist[LVL_W-1] ? (LVL_W'(0) - r_dist) : r_dist;
    assign w_off    = w_quot[HUE_W-1:0];
    assign w_h6     = ({3'b000, r_shown} << 2) + ({3'b000, r_shown} << 1);
    assign w_sector = w_h6[18:16];
    assign w_f      = w_h6[HUE_W-1:0];
    assign w_prodq  = w_prod[HUE_W +: LVL_W];

    always_comb begin
        w_mul_req = '0;
        unique case (r_state)
            ST_NORM: begin
                w_mul_req.a = MUL_W'(r_mant[FRAC_W-1:0]);
                w_mul_req.b = MUL_W'(LOG_TABLE_DEPTH);
            end
            ST_LUT: begin
                w_mul_req.a = MUL_W'(w_diff);
                w_mul_req.b = MUL_W'(r_rfrac);
            end
            ST_GMUL: begin
                w_mul_req.a = MUL_W'(w_mag);
                w_mul_req.b = MUL_W'(r_pos);
            end
            ST_HP: begin
                w_mul_req.a = MUL_W'(w_v);
                w_mul_req.b = MUL_W'(Q_ONE - w_s);
            end
            ST_HSF: begin
                w_mul_req.a = MUL_W'(w_s);
                w_mul_req.b = MUL_W'(w_f);
            end
            ST_HQ, ST_HT: begin
                w_mul_req.a = MUL_W'(w_v);
                w_mul_req.b = MUL_W'(Q_ONE - w_prodq);
            end
            ST_HSFN: begin
                w_mul_req.a = MUL_W'(w_s);
                w_mul_req.b = MUL_W'(Q_ONE - {1'b0, w_f});
            end
            default: begin
            end
        endcase
    end

    assign w_div_req.start    = (r_state == ST_DSTART);
    assign w_div_req.dividend = w_prod[DIV_W-1:0];
    assign w_div_req.divisor  = w_steps;

    always_comb begin
        case (w_sector)
            3'd0: begin
                w_rr = w_v;   w_gg = r_tt;    w_bb = r_pp;
            end
            3'd1: begin
                w_rr = r_qq;  w_gg = w_v;     w_bb = r_pp;
            end
            3'd2: begin
                w_rr = r_pp;  w_gg = w_v;     w_bb = r_tt;
            end
            3'd3: begin
                w_rr = r_pp;  w_gg = r_qq;    w_bb = w_v;
            end
            3'd4: begin
                w_rr = r_tt;  w_gg = r_pp;    w_bb = w_v;
            end
            default: begin
                w_rr = w_v;   w_gg = r_pp;    w_bb = r_qq;
            end
        endcase
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_load    = (r_state == ST_OUT) && (!r_out_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_start  <= '0;
            r_target <= '0;
            r_dist   <= '0;
            r_pos    <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        if (w_mid) begin
                            r_state <= ST_GMUL;
                        end else if (s_axis_tdata[MANT_W-1:0] == '0) begin
                            r_state <= ST_INTERP;
                        end else begin
                            r_state <= ST_NORM;
                        end
                    end
                end
                ST_NORM: begin
                    if (r_mant[MANT_W-1]) begin
                        r_state <= ST_KMUL;
                    end
                end
                ST_KMUL:   r_state <= ST_LUT;
                ST_LUT:    r_state <= ST_INTERP;
                ST_INTERP: begin
                    if (r_pos == '0) begin
                        r_start  <= w_newhue;
                        r_target <= w_newhue;
                        r_dist   <= '0;
                    end else begin
                        r_start  <= r_target;
                        r_target <= w_newhue;
                        r_dist   <= w_fold[LVL_W-1:0];
                    end
                    r_pos   <= STEP_W'(1);
                    r_state <= ST_HP;
                end
                ST_GMUL:   r_state <= ST_DSTART;
                ST_DSTART: r_state <= ST_DWAIT;
                ST_DWAIT: begin
                    if (!w_div_busy) begin
                        r_pos   <= r_pos + STEP_W'(1);
                        r_state <= ST_HP;
                    end
                end
                ST_HP:   r_state <= ST_HSF;
                ST_HSF:  r_state <= ST_HQ;
                ST_HQ:   r_state <= ST_HSFN;
                ST_HSFN: r_state <= ST_HT;
                ST_HT:   r_state <= ST_TT;
                ST_TT:   r_state <= ST_OUT;
                ST_OUT: begin
                    if (w_out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mant <= s_axis_tdata[MANT_W-1:0];
            r_zero <= (s_axis_tdata[MANT_W-1:0] == '0);
        end else if (r_state == ST_NORM && !r_mant[MANT_W-1]) begin
            r_mant <= r_mant << 1;
        end
        if (r_state == ST_KMUL) begin
            r_kidx  <= w_prod[FRAC_W +: KW];
            r_rfrac <= w_prod[FRAC_W-1:0];
        end
        if (r_state == ST_LUT) begin
            r_lo <= w_lo;
        end
        if (r_state == ST_INTERP) begin
            r_shown <= (r_pos == '0) ? w_newhue : r_target;
        end
        if (r_state == ST_DWAIT && !w_div_busy) begin
            r_shown <= r_dist[LVL_W-1] ? (r_start - w_off) : (r_start + w_off);
        end
        if (r_state == ST_HSF) begin
            r_pp <= w_prodq;
        end
        if (r_state == ST_HSFN) begin
            r_qq <= w_prodq;
        end
        if (r_state == ST_TT) begin
            r_tt <= w_prodq;
        end
        if (w_out_load) begin
            r_out_data <= {r_shown, sat16(w_bb), sat16(w_gg), sat16(w_rr)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
